// ===== hw/rtl/ibst_pkg.sv =====
// ----------------------------------------------------------------------------
// ibst_pkg
// Shared types and constants for the implicit binary search tree block:
// operation codes, result kinds, field widths and the command and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package ibst_pkg;

    localparam int VALUE_W = 32;
    localparam int SLOT_W  = 7;
    localparam int OP_W    = 2;

    // Operation codes of an input item; the fourth code is ignored
    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_BUILD  = 2'd1,
        OP_SEARCH = 2'd2
    } op_t;

    // Result kinds
    localparam logic KIND_NODE   = 1'b0;
    localparam logic KIND_SEARCH = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic load;         // append value to staging store
        logic build_init;   // latch tree shape, clear load count
        logic search_init;  // latch key, start walk at root
        logic stage_read;   // compute source position, read staging store
        logic node_emit;    // write tree node, report it, advance
        logic node_read;    // read tree node at walk slot
        logic walk_step;    // descend to a child
        logic emit_miss;    // report walk end without a match
        logic emit_hit;     // report matching node
    } ibst_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic count_zero;   // nothing loaded
        logic build_last;   // current node is the last one of the tree
        logic walk_out;     // walk slot is empty or past the array
        logic key_hit;      // node read back holds the key
    } ibst_stat_t;

endpackage

// ===== hw/rtl/ibst_ctrl.sv =====
// ----------------------------------------------------------------------------
// ibst_ctrl
// Controller state machine: accepts items, sequences the per-node build
// steps and the per-level search steps, and drives datapath commands.
// ----------------------------------------------------------------------------
module ibst_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [ibst_pkg::OP_W-1:0]     operation,
    input  ibst_pkg::ibst_stat_t          stat,
    output ibst_pkg::ibst_cmd_t           cmd,
    output logic                          busy
);
    import ibst_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_BREAD = 6'b000010,
        ST_BEMIT = 6'b000100,
        ST_SCHK  = 6'b001000,
        ST_SCMP  = 6'b010000,
        ST_SPARE = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (operation)
                        OP_LOAD:
                        begin
                            cmd.load = 1'b1;
                        end
                        OP_BUILD:
                        begin
                            cmd.build_init = 1'b1;
                            if (!stat.count_zero)
                            begin
                                state_next = ST_BREAD;
                            end
                        end
                        OP_SEARCH:
                        begin
                            cmd.search_init = 1'b1;
                            state_next      = ST_SCHK;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_BREAD:
            begin
                cmd.stage_read = 1'b1;
                state_next     = ST_BEMIT;
            end
            ST_BEMIT:
            begin
                cmd.node_emit = 1'b1;
                state_next    = stat.build_last ? ST_IDLE : ST_BREAD;
            end
            ST_SCHK:
            begin
                if (stat.walk_out)
                begin
                    cmd.emit_miss = 1'b1;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    cmd.node_read = 1'b1;
                    state_next    = ST_SCMP;
                end
            end
            ST_SCMP:
            begin
                if (stat.key_hit)
                begin
                    cmd.emit_hit = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    cmd.walk_step = 1'b1;
                    state_next    = ST_SCHK;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hw/rtl/ibst_dpath.sv =====
// ----------------------------------------------------------------------------
// ibst_dpath
// Datapath: staging store and load count, tree node store, build position
// arithmetic, search walk register and the result registers.
// ----------------------------------------------------------------------------
module ibst_dpath #(
    parameter int MAX_KEYS   = 63,
    parameter int TREE_SLOTS = 128
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  ibst_pkg::ibst_cmd_t                  cmd,
    input  logic signed [ibst_pkg::VALUE_W-1:0]  value,
    output ibst_pkg::ibst_stat_t                 stat,
    output logic                                 valid,
    output logic                                 kind,
    output logic [ibst_pkg::SLOT_W-1:0]          slot,
    output logic signed [ibst_pkg::VALUE_W-1:0]  node_value,
    output logic                                 color,
    output logic                                 found,
    output logic                                 last
);
    import ibst_pkg::*;

    localparam int KW  = $clog2(MAX_KEYS + 1);              // load count width
    localparam int SAW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int NAW = $clog2(TREE_SLOTS);                // node address width
    localparam int CW  = KW + 1;                            // position arithmetic
    localparam int DW  = $clog2(KW + 1);                    // tree level width

    // Highest set bit of a count
    function automatic logic [DW-1:0] flog2(input logic [KW-1:0] x);
        logic [DW-1:0] r;
        r = '0;
        for (int i = 0; i < KW; i++)
        begin
            if (x[i])
            begin
                r = DW'(i);
            end
        end
        return r;
    endfunction

    // Stores
    logic signed [VALUE_W-1:0] stage_mem [MAX_KEYS];
    logic        [VALUE_W:0]   node_mem  [TREE_SLOTS];   // {color, value}

    // Control registers
    logic [KW-1:0]  count_reg,      count_next;
    logic [NAW-1:0] tree_count_reg, tree_count_next;
    logic           valid_reg;

    // Build registers
    logic [KW-1:0]  n_reg;
    logic [DW-1:0]  h_reg;
    logic [KW-1:0]  leaves_reg;
    logic           perfect_reg;
    logic [NAW-1:0] mi_reg;
    logic [NAW-1:0] j_reg;
    logic [DW-1:0]  d_reg;
    logic           pos_ok_reg;
    logic signed [VALUE_W-1:0] stage_rdata_reg;

    // Search registers
    logic [NAW:0]               cur_reg;
    logic signed [VALUE_W-1:0]  key_reg;
    logic [VALUE_W:0]           node_rdata_reg;

    // Result registers
    logic                       kind_reg;
    logic [SLOT_W-1:0]          slot_reg;
    logic signed [VALUE_W-1:0]  value_reg;
    logic                       color_reg;
    logic                       found_reg;
    logic                       last_reg;

    // Combinational helpers
    logic [DW-1:0]     h_new;
    logic [CW-1:0]     n_ext;
    logic [DW-1:0]     shamt;
    logic [CW-1:0]     ci, alt, pos;
    logic [SAW-1:0]    stage_addr;
    logic              red;
    logic              level_end;
    logic              key_less;
    logic              full;

    assign full  = (count_reg >= KW'(MAX_KEYS));
    assign h_new = flog2(count_reg);
    assign n_ext = CW'(count_reg);

    // Source position of the node at slot mi: level d, index j in level
    assign shamt      = h_reg - d_reg;
    assign ci         = CW'({j_reg, 1'b1}) << shamt;
    assign alt        = ci - (ci >> 1) + CW'(leaves_reg);
    assign pos        = (ci < alt) ? ci : alt;
    assign stage_addr = SAW'(pos - CW'(1));

    assign red       = (d_reg == h_reg) && !perfect_reg;
    assign level_end = ((NAW + 1)'(j_reg) + (NAW + 1)'(1)) == ((NAW + 1)'(1) << d_reg);
    assign key_less  = $signed(node_rdata_reg[VALUE_W-1:0]) < key_reg;

    // Status
    assign stat.count_zero = (count_reg == '0);
    assign stat.build_last = (mi_reg == tree_count_reg);
    assign stat.walk_out   = (cur_reg >= (NAW + 1)'(TREE_SLOTS))
                          || (cur_reg > (NAW + 1)'(tree_count_reg));
    assign stat.key_hit    = (node_rdata_reg[VALUE_W-1:0] == key_reg);

    // Load count and tree size
    always_comb
    begin
        count_next      = count_reg;
        tree_count_next = tree_count_reg;
        if (cmd.load && !full)
        begin
            count_next = count_reg + KW'(1);
        end
        if (cmd.build_init)
        begin
            count_next = '0;
            if (int'(count_reg) > TREE_SLOTS - 1)
            begin
                tree_count_next = NAW'(TREE_SLOTS - 1);
            end
            else
            begin
                tree_count_next = NAW'(count_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            tree_count_reg <= '0;
            valid_reg      <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            tree_count_reg <= tree_count_next;
            valid_reg      <= cmd.node_emit || cmd.emit_miss || cmd.emit_hit;
        end
    end

    // Staging store: written by loads, read during build
    always_ff @(posedge clk)
    begin
        if (cmd.load && !full)
        begin
            stage_mem[count_reg[SAW-1:0]] <= value;
        end
        if (cmd.stage_read)
        begin
            stage_rdata_reg <= stage_mem[stage_addr];
        end
    end

    // Tree node store: written by build, read by search
    always_ff @(posedge clk)
    begin
        if (cmd.node_emit)
        begin
            node_mem[mi_reg] <= {red, (pos_ok_reg ? stage_rdata_reg : '0)};
        end
        if (cmd.node_read)
        begin
            node_rdata_reg <= node_mem[cur_reg[NAW-1:0]];
        end
    end

    // Build shape and node walk
    always_ff @(posedge clk)
    begin
        if (cmd.build_init)
        begin
            n_reg       <= count_reg;
            h_reg       <= h_new;
            leaves_reg  <= KW'(n_ext + CW'(1) - (CW'(1) << h_new));
            perfect_reg <= (((n_ext + CW'(1)) & n_ext) == '0);
            mi_reg      <= NAW'(1);
            j_reg       <= '0;
            d_reg       <= '0;
        end
        if (cmd.stage_read)
        begin
            pos_ok_reg <= (pos <= CW'(n_reg));
        end
        if (cmd.node_emit)
        begin
            mi_reg <= mi_reg + NAW'(1);
            if (level_end)
            begin
                j_reg <= '0;
                d_reg <= d_reg + DW'(1);
            end
            else
            begin
                j_reg <= j_reg + NAW'(1);
            end
        end
    end

    // Search walk
    always_ff @(posedge clk)
    begin
        if (cmd.search_init)
        begin
            key_reg <= value;
            cur_reg <= (NAW + 1)'(1);
        end
        if (cmd.walk_step)
        begin
            cur_reg <= {cur_reg[NAW-1:0], key_less};
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (cmd.node_emit)
        begin
            kind_reg  <= KIND_NODE;
            slot_reg  <= SLOT_W'(mi_reg);
            value_reg <= pos_ok_reg ? stage_rdata_reg : '0;
            color_reg <= red;
            found_reg <= 1'b0;
            last_reg  <= stat.build_last;
        end
        if (cmd.emit_miss)
        begin
            kind_reg  <= KIND_SEARCH;
            slot_reg  <= SLOT_W'(cur_reg);
            value_reg <= '0;
            color_reg <= 1'b0;
            found_reg <= 1'b0;
            last_reg  <= 1'b1;
        end
        if (cmd.emit_hit)
        begin
            kind_reg  <= KIND_SEARCH;
            slot_reg  <= SLOT_W'(cur_reg);
            value_reg <= node_rdata_reg[VALUE_W-1:0];
            color_reg <= node_rdata_reg[VALUE_W];
            found_reg <= 1'b1;
            last_reg  <= 1'b1;
        end
    end

    assign valid      = valid_reg;
    assign kind       = kind_reg;
    assign slot       = slot_reg;
    assign node_value = value_reg;
    assign color      = color_reg;
    assign found      = found_reg;
    assign last       = last_reg;

endmodule

// ===== hw/rtl/implicit_bst_build_and_search.sv =====
// ----------------------------------------------------------------------------
// implicit_bst_build_and_search
// Top level: loads sorted values, builds an array-layout binary search tree
// and searches it. Controller and datapath joined by command/status bundles.
// ----------------------------------------------------------------------------
// Load: busy stays low, no result.
// Build of n nodes: each node is a staging read and then a node write with its
//   report, one step each on single-port stores.
// Search: the tree has at most six levels here; each level visited is one
//   registered node-store read plus one compare, and a miss ends with a final
//   walk check.
// Results are registered and shown for one cycle on valid; the receiver
//   cannot stall. Reset clears the load count and empties the tree at once.
module implicit_bst_build_and_search #(
    parameter int MAX_KEYS   = 63,
    parameter int TREE_SLOTS = 128
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [ibst_pkg::OP_W-1:0]            operation,
    input  logic signed [ibst_pkg::VALUE_W-1:0]  value,
    output logic                                 valid,
    output logic                                 kind,
    output logic [ibst_pkg::SLOT_W-1:0]          slot,
    output logic signed [ibst_pkg::VALUE_W-1:0]  node_value,
    output logic                                 color,
    output logic                                 found,
    output logic                                 last
);
    import ibst_pkg::*;

    ibst_cmd_t  cmd;
    ibst_stat_t stat;

    // Sequencer
    ibst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (operation),
        .stat      (stat),
        .cmd       (cmd),
        .busy      (busy)
    );

    // Stores and arithmetic
    ibst_dpath #(
        .MAX_KEYS   (MAX_KEYS),
        .TREE_SLOTS (TREE_SLOTS)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .value      (value),
        .stat       (stat),
        .valid      (valid),
        .kind       (kind),
        .slot       (slot),
        .node_value (node_value),
        .color      (color),
        .found      (found),
        .last       (last)
    );

endmodule

// ===== hw/rtl/ibst_checker.sv =====
// ----------------------------------------------------------------------------
// ibst_checker
// Port-level checks on the implicit binary search tree block, bound to the
// top level.
// ----------------------------------------------------------------------------
module ibst_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic                                 busy,
    input  logic [ibst_pkg::OP_W-1:0]            operation,
    input  logic                                 valid,
    input  logic                                 kind,
    input  logic [ibst_pkg::SLOT_W-1:0]          slot,
    input  logic signed [ibst_pkg::VALUE_W-1:0]  node_value,
    input  logic                                 color,
    input  logic                                 found,
    input  logic                                 last
);
    import ibst_pkg::*;

    // An accepted search always occupies the block
    a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && operation == OP_SEARCH) |=> busy)
        else $error("search accepted but block not busy");

    // Leaving busy always coincides with the final result of the item
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> (valid && last))
        else $error("busy dropped without a final result");

    // A missed search reports zero value and black
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && kind == KIND_SEARCH && !found) |-> (node_value == '0 && !color && last))
        else $error("missed search carries node data");

    // Node reports never claim a match and never name slot zero
    a_node_report: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && kind == KIND_NODE) |-> (!found && slot != '0))
        else $error("malformed node report");

endmodule

bind implicit_bst_build_and_search ibst_checker u_ibst_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .operation  (operation),
    .valid      (valid),
    .kind       (kind),
    .slot       (slot),
    .node_value (node_value),
    .color      (color),
    .found      (found),
    .last       (last)
);
